### src/ftrw_pkg.sv
// shared types, constants and address helpers for the fm tone register writer
// no dependencies
package ftrw_pkg;

   localparam int CHANNELS = 9;
   localparam int NBEATS   = 5;

   localparam logic MODE_PATCH = 1'b0;
   localparam logic MODE_TONE  = 1'b1;

   localparam logic [3:0] PIDX_MOD_CHARS = 4'd0;
   localparam logic [3:0] PIDX_CAR_CHARS = 4'd1;
   localparam logic [3:0] PIDX_CAR_KSL   = 4'd3;
   localparam logic [3:0] PIDX_FEEDBACK  = 4'd10;

   localparam logic [7:0] BASE_CHARS    = 8'h20;
   localparam logic [7:0] BASE_KSL      = 8'h40;
   localparam logic [7:0] BASE_ATTACK   = 8'h60;
   localparam logic [7:0] BASE_SUSTAIN  = 8'h80;
   localparam logic [7:0] BASE_WAVE     = 8'hE0;
   localparam logic [7:0] BASE_FEEDBACK = 8'hC0;
   localparam logic [7:0] BASE_FNUM_LO  = 8'hA0;
   localparam logic [7:0] BASE_KEY_BLK  = 8'hB0;
   localparam logic [7:0] CHARS_HI_MASK = 8'hF0;
   localparam logic [1:0] KEY_ON_PAD    = 2'b01;
   localparam logic [5:0] VOLUME_MAX    = 6'd63;

   localparam logic [3:0] GROUP_A_LAST = 4'd2;
   localparam logic [3:0] GROUP_B_LAST = 4'd5;
   localparam logic [7:0] GROUP_SKIP   = 8'd5;
   localparam logic [7:0] CAR_OFFSET   = 8'd3;

   // m must stay below 1024 * 128 * 3125 / 65536 for a block of at most 7
   localparam logic [14:0] FIT_LIMIT = 15'd6250;
   localparam int          FIT_LIMIT_INT = 6250;
   // floor(m * 65536 / 3125) = (m * ceil(2^41 / 3125)) >> 25, exact for m below 10737
   localparam logic [29:0] FNUM_RECIP = 30'd703687442;
   localparam int          FNUM_SHIFT = 25;

   typedef struct packed {
      logic        mode;
      logic [3:0]  channel;
      logic [3:0]  patch_index;
      logic [7:0]  patch_byte;
      logic [14:0] frequency;
      logic [5:0]  volume;
   } req_type;

   typedef struct packed {
      logic [1:0] scale;
      logic [7:0] mod_chars;
      logic [7:0] car_chars;
   } chan_type;

   typedef struct packed {
      logic       mod_we;
      logic       car_we;
      logic       scale_we;
      logic [3:0] channel;
      logic [7:0] data;
   } store_wr_type;

   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] data;
   } beat_type;

   typedef struct packed {
      logic [2:0]                count;
      beat_type [NBEATS-1:0]     beats;
   } batch_type;

   typedef struct packed {
      logic       free;
      logic [2:0] count;
      logic [2:0] pos;
   } qstat_type;

   function automatic logic [7:0] op_base(logic [2:0] sel);
      logic [7:0] b;
      unique case (sel)
         3'd0:    b = BASE_CHARS;
         3'd1:    b = BASE_KSL;
         3'd2:    b = BASE_ATTACK;
         3'd3:    b = BASE_SUSTAIN;
         3'd4:    b = BASE_WAVE;
         default: b = BASE_CHARS;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] op_addr(logic [7:0] base, logic [3:0] ch, logic car);
      logic [7:0] a;
      a = base + {4'd0, ch};
      if (ch > GROUP_A_LAST) a = a + GROUP_SKIP;
      if (ch > GROUP_B_LAST) a = a + GROUP_SKIP;
      if (car) a = a + CAR_OFFSET;
      return a;
   endfunction

endpackage

### src/ftrw_channels_if.sv
// valid/ready channel interfaces for command items and register write beats
// depends on nothing
interface ftrw_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [3:0]  channel;
   logic [3:0]  patch_index;
   logic [7:0]  patch_byte;
   logic [14:0] frequency;
   logic [5:0]  volume;

   modport source (output valid, mode, channel, patch_index, patch_byte, frequency, volume,
                   input ready);
   modport sink   (input valid, mode, channel, patch_index, patch_byte, frequency, volume,
                   output ready);
endinterface

interface ftrw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reg_addr;
   logic [7:0] reg_data;
   logic       last;

   modport source (output valid, reg_addr, reg_data, last, input ready);
   modport sink   (input valid, reg_addr, reg_data, last, output ready);
endinterface

### src/ftrw_store.sv
// per-channel operator characteristics and carrier level-scale bits
// depends on ftrw_pkg
module ftrw_store (
   input  logic                  clock,
   input  logic                  reset,
   input  ftrw_pkg::store_wr_type wr,
   input  logic [3:0]            rd_channel,
   output ftrw_pkg::chan_type     rd_data
);

   ftrw_pkg::chan_type entry_ff [ftrw_pkg::CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ftrw_pkg::CHANNELS; i++) begin
            entry_ff[i] <= '0;
         end
      end else if (wr.channel < 4'(ftrw_pkg::CHANNELS)) begin
         if (wr.mod_we)   entry_ff[wr.channel].mod_chars <= wr.data;
         if (wr.car_we)   entry_ff[wr.channel].car_chars <= wr.data;
         if (wr.scale_we) entry_ff[wr.channel].scale     <= wr.data[7:6];
      end
   end

   always_comb begin
      if (rd_channel < 4'(ftrw_pkg::CHANNELS)) begin
         rd_data = entry_ff[rd_channel];
      end else begin
         rd_data = '0;
      end
   end

endmodule

### src/ftrw_calc.sv
// builds the register write batch for one command and the store update it causes
// depends on ftrw_pkg
module ftrw_calc (
   input  ftrw_pkg::req_type      item,
   input  ftrw_pkg::chan_type     chan,
   output ftrw_pkg::batch_type    batch,
   output ftrw_pkg::store_wr_type wr
);

   logic        ch_ok;
   logic [1:0]  shamt;
   logic [14:0] m;
   logic        fits;
   logic [42:0] prod;
   logic [16:0] f;
   logic [2:0]  blk;
   logic [9:0]  fnum;
   logic [7:0]  mm;
   logic [7:0]  cm;

   assign ch_ok = item.channel < 4'(ftrw_pkg::CHANNELS);

   // smallest of the multipliers 1, 2, 4, 8 that brings the quotient in range
   always_comb begin
      priority if (item.frequency < ftrw_pkg::FIT_LIMIT) begin
         shamt = 2'd0;
      end else if (item.frequency < 15'(2 * ftrw_pkg::FIT_LIMIT_INT)) begin
         shamt = 2'd1;
      end else if (item.frequency < 15'(4 * ftrw_pkg::FIT_LIMIT_INT)) begin
         shamt = 2'd2;
      end else begin
         shamt = 2'd3;
      end
   end

   assign m    = item.frequency >> shamt;
   assign fits = m < ftrw_pkg::FIT_LIMIT;
   assign prod = 43'(m[12:0]) * 43'(ftrw_pkg::FNUM_RECIP);
   assign f    = prod[ftrw_pkg::FNUM_SHIFT+16:ftrw_pkg::FNUM_SHIFT];

   always_comb begin
      priority if (f[16]) blk = 3'd7;
      else if (f[15]) blk = 3'd6;
      else if (f[14]) blk = 3'd5;
      else if (f[13]) blk = 3'd4;
      else if (f[12]) blk = 3'd3;
      else if (f[11]) blk = 3'd2;
      else if (f[10]) blk = 3'd1;
      else blk = 3'd0;
   end

   assign fnum = 10'(f >> blk);
   assign mm   = {4'd0, chan.mod_chars[3:0]} << shamt;
   assign cm   = {4'd0, chan.car_chars[3:0]} << shamt;

   always_comb begin
      batch      = '0;
      wr         = '0;
      wr.channel = item.channel;
      wr.data    = item.patch_byte;
      if (ch_ok) begin
         unique case (item.mode)
            ftrw_pkg::MODE_PATCH: begin
               if (item.patch_index == ftrw_pkg::PIDX_FEEDBACK) begin
                  batch.count         = 3'd1;
                  batch.beats[0].addr = ftrw_pkg::BASE_FEEDBACK + {4'd0, item.channel};
                  batch.beats[0].data = item.patch_byte;
               end else if (item.patch_index < ftrw_pkg::PIDX_FEEDBACK) begin
                  batch.count         = 3'd1;
                  batch.beats[0].addr = ftrw_pkg::op_addr(
                     ftrw_pkg::op_base(item.patch_index[3:1]), item.channel,
                     item.patch_index[0]);
                  batch.beats[0].data = item.patch_byte;
                  wr.mod_we   = item.patch_index == ftrw_pkg::PIDX_MOD_CHARS;
                  wr.car_we   = item.patch_index == ftrw_pkg::PIDX_CAR_CHARS;
                  wr.scale_we = item.patch_index == ftrw_pkg::PIDX_CAR_KSL;
               end
            end
            ftrw_pkg::MODE_TONE: begin
               if (fits && mm[7:4] == 4'd0 && cm[7:4] == 4'd0) begin
                  batch.count         = 3'(ftrw_pkg::NBEATS);
                  batch.beats[0].addr = ftrw_pkg::op_addr(ftrw_pkg::BASE_CHARS,
                                                          item.channel, 1'b0);
                  batch.beats[0].data = (chan.mod_chars & ftrw_pkg::CHARS_HI_MASK) | mm;
                  batch.beats[1].addr = ftrw_pkg::op_addr(ftrw_pkg::BASE_CHARS,
                                                          item.channel, 1'b1);
                  batch.beats[1].data = (chan.car_chars & ftrw_pkg::CHARS_HI_MASK) | cm;
                  batch.beats[2].addr = ftrw_pkg::op_addr(ftrw_pkg::BASE_KSL,
                                                          item.channel, 1'b1);
                  batch.beats[2].data = {chan.scale, ftrw_pkg::VOLUME_MAX - item.volume};
                  batch.beats[3].addr = ftrw_pkg::BASE_FNUM_LO + {4'd0, item.channel};
                  batch.beats[3].data = fnum[7:0];
                  batch.beats[4].addr = ftrw_pkg::BASE_KEY_BLK + {4'd0, item.channel};
                  batch.beats[4].data = {ftrw_pkg::KEY_ON_PAD, blk, fnum[9:8]};
               end
            end
            default: begin
               batch = '0;
            end
         endcase
      end
   end

endmodule

### src/ftrw_beat_queue.sv
// result register holding one batch of register writes, sent one beat at a time
// depends on ftrw_pkg and ftrw_channels_if
module ftrw_beat_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  ftrw_pkg::batch_type batch,
   ftrw_rsp_if.source          rsp,
   output ftrw_pkg::qstat_type stat
);

   logic [2:0]                               count_ff, count_in;
   logic [2:0]                               pos_ff, pos_in;
   ftrw_pkg::beat_type [ftrw_pkg::NBEATS-1:0] beats_ff;
   logic                                     last_beat;
   logic                                     taken;

   assign last_beat    = pos_ff == (count_ff - 3'd1);
   assign taken        = rsp.valid && rsp.ready;
   assign rsp.valid    = count_ff != 3'd0;
   assign rsp.reg_addr = beats_ff[pos_ff].addr;
   assign rsp.reg_data = beats_ff[pos_ff].data;
   assign rsp.last     = last_beat;

   assign stat.free  = (count_ff == 3'd0) || (taken && last_beat);
   assign stat.count = count_ff;
   assign stat.pos   = pos_ff;

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      if (load) begin
         count_in = batch.count;
         pos_in   = 3'd0;
      end else if (taken) begin
         if (last_beat) begin
            count_in = 3'd0;
            pos_in   = 3'd0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         pos_ff   <= 3'd0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beats_ff <= batch.beats;
      end
   end

endmodule

### src/fm_tone_register_writer.sv
// top level: command input register, batch builder, channel store and beat queue
// depends on ftrw_pkg, ftrw_channels_if, ftrw_store, ftrw_calc, ftrw_beat_queue
//
//   channel | dir | beat carries
//   req     | in  | mode, channel, patch_index, patch_byte, frequency, volume
//   rsp     | out | reg_addr, reg_data, last
//
// a command waits in the input register until the result register is free, then its whole batch
// is built in one pass and loaded into the result register; patch commands give one beat and
// tone commands five; items on an invalid channel or index, or tones out of range, give none
// a new command is taken every cycle while the result register frees up
// synchronous reset clears the channel store and both valid flags and holds req.ready low
// rsp stalls hold the batch; the input register fills and then req.ready drops
module fm_tone_register_writer (
   input logic        clock,
   input logic        reset,
   ftrw_req_if.sink   req,
   ftrw_rsp_if.source rsp
);

   logic                   a_valid_ff, a_valid_in;
   ftrw_pkg::req_type      a_item_ff;
   logic                   a_move;
   logic                   accept;
   ftrw_pkg::chan_type     chan;
   ftrw_pkg::batch_type    batch;
   ftrw_pkg::store_wr_type wr_raw;
   ftrw_pkg::store_wr_type wr;
   ftrw_pkg::qstat_type    qstat;

   assign a_move    = a_valid_ff && qstat.free;
   assign req.ready = !reset && (!a_valid_ff || a_move);
   assign accept    = req.valid && req.ready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_item_ff.mode        <= req.mode;
         a_item_ff.channel     <= req.channel;
         a_item_ff.patch_index <= req.patch_index;
         a_item_ff.patch_byte  <= req.patch_byte;
         a_item_ff.frequency   <= req.frequency;
         a_item_ff.volume      <= req.volume;
      end
   end

   always_comb begin
      wr          = wr_raw;
      wr.mod_we   = wr_raw.mod_we && a_move;
      wr.car_we   = wr_raw.car_we && a_move;
      wr.scale_we = wr_raw.scale_we && a_move;
   end

   ftrw_store u_store (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .rd_channel (a_item_ff.channel),
      .rd_data    (chan)
   );

   ftrw_calc u_calc (
      .item  (a_item_ff),
      .chan  (chan),
      .batch (batch),
      .wr    (wr_raw)
   );

   ftrw_beat_queue u_queue (
      .clock (clock),
      .reset (reset),
      .load  (a_move),
      .batch (batch),
      .rsp   (rsp),
      .stat  (qstat)
   );

`ifndef SYNTH
   a_pos_in_batch: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (qstat.pos < qstat.count))
      else $error("beat position outside batch");

   a_batch_size: assert property (@(posedge clock) disable iff (reset)
      (qstat.count == 3'd0) || (qstat.count == 3'd1) || (qstat.count == 3'd5))
      else $error("batch size is neither one nor five beats");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      (a_move && batch.count != 3'd0) |=> (rsp.valid && qstat.pos == 3'd0))
      else $error("loaded batch does not start at its first beat");
`endif

endmodule

### tb/fm_tone_register_writer_tb.sv
// testbench for fm_tone_register_writer: patch and tone commands in, register write beats out
// depends on ftrw_pkg, ftrw_channels_if and the fm_tone_register_writer rtl
// beats are checked in order against a shadow of the channel store kept in the testbench
module fm_tone_register_writer_tb;

   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] data;
      logic       last;
   } reg_write_type;

   localparam int          IDLE_LIMIT   = 2000;
   localparam int          DRAIN_CYCLES = 20;
   localparam logic [7:0]  KEY_ON_BIT   = 8'h20;
   localparam logic [9:0]  FNUM_MAX     = 10'h3FF;

   logic clock;
   logic reset;

   ftrw_req_if req_ch ();
   ftrw_rsp_if rsp_ch ();

   fm_tone_register_writer i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   reg_write_type pending_writes[$];
   logic [7:0]    mod_chars_shadow [ftrw_pkg::CHANNELS];
   logic [7:0]    car_chars_shadow [ftrw_pkg::CHANNELS];
   logic [1:0]    car_scale_shadow [ftrw_pkg::CHANNELS];
   int unsigned   freq_mults [5] = '{1, 2, 4, 8, 15};
   int            err_count;
   int            idle_cycles;
   int            rsp_stall_left;
   bit            no_gaps;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] chan_slot(logic [3:0] ch);
      case (ch)
         4'd0: return 8'd0;
         4'd1: return 8'd1;
         4'd2: return 8'd2;
         4'd3: return 8'd8;
         4'd4: return 8'd9;
         4'd5: return 8'd10;
         4'd6: return 8'd16;
         4'd7: return 8'd17;
         default: return 8'd18;
      endcase
   endfunction

   function automatic logic [7:0] patch_base(logic [2:0] pair);
      case (pair)
         3'd0: return ftrw_pkg::BASE_CHARS;
         3'd1: return ftrw_pkg::BASE_KSL;
         3'd2: return ftrw_pkg::BASE_ATTACK;
         3'd3: return ftrw_pkg::BASE_SUSTAIN;
         default: return ftrw_pkg::BASE_WAVE;
      endcase
   endfunction

   function automatic logic [7:0] operator_reg(logic [7:0] base, logic [3:0] ch, logic car);
      return base + chan_slot(ch) + (car ? 8'd3 : 8'd0);
   endfunction

   // block is the number of halvings needed to bring the f-number into 10 bits
   function automatic bit freq_to_block(int unsigned m, output logic [2:0] blk,
                                        output logic [9:0] fnum);
      longint unsigned f;
      int              b;
      f = (64'd65536 * m) / 64'd3125;
      b = 0;
      while (f > FNUM_MAX && b < 8) begin
         b++;
         f = f >> 1;
      end
      blk  = b[2:0];
      fnum = f[9:0];
      return b <= 7;
   endfunction

   function automatic void push_write(logic [7:0] addr, logic [7:0] data, logic last);
      reg_write_type w;
      w.addr = addr;
      w.data = data;
      w.last = last;
      pending_writes.push_back(w);
   endfunction

   function automatic bit is_effective(ftrw_pkg::req_type c);
      return c.channel < ftrw_pkg::CHANNELS &&
             (c.mode == ftrw_pkg::MODE_TONE || c.patch_index <= ftrw_pkg::PIDX_FEEDBACK);
   endfunction

   function automatic void predict_writes(ftrw_pkg::req_type c);
      logic [2:0]  blk;
      logic [9:0]  fnum;
      int unsigned mult;
      int unsigned mod_mult;
      int unsigned car_mult;
      bit          fits;
      if (!is_effective(c)) return;
      if (c.mode == ftrw_pkg::MODE_PATCH) begin
         if (c.patch_index == ftrw_pkg::PIDX_FEEDBACK) begin
            push_write(ftrw_pkg::BASE_FEEDBACK + {4'd0, c.channel}, c.patch_byte, 1'b1);
            return;
         end
         push_write(operator_reg(patch_base(c.patch_index[3:1]), c.channel, c.patch_index[0]),
                    c.patch_byte, 1'b1);
         if (c.patch_index == ftrw_pkg::PIDX_MOD_CHARS)
            mod_chars_shadow[c.channel] = c.patch_byte;
         else if (c.patch_index == ftrw_pkg::PIDX_CAR_CHARS)
            car_chars_shadow[c.channel] = c.patch_byte;
         else if (c.patch_index == ftrw_pkg::PIDX_CAR_KSL)
            car_scale_shadow[c.channel] = c.patch_byte[7:6];
         return;
      end
      fits = 0;
      mult = 0;
      for (int i = 0; i < 5 && !fits; i++) begin
         mult = freq_mults[i];
         fits = freq_to_block(c.frequency / mult, blk, fnum);
      end
      if (!fits) return;
      mod_mult = mod_chars_shadow[c.channel][3:0] * mult;
      car_mult = car_chars_shadow[c.channel][3:0] * mult;
      if (mod_mult > 15 || car_mult > 15) return;
      push_write(operator_reg(ftrw_pkg::BASE_CHARS, c.channel, 1'b0),
                 (mod_chars_shadow[c.channel] & ftrw_pkg::CHARS_HI_MASK) | mod_mult[7:0],
                 1'b0);
      push_write(operator_reg(ftrw_pkg::BASE_CHARS, c.channel, 1'b1),
                 (car_chars_shadow[c.channel] & ftrw_pkg::CHARS_HI_MASK) | car_mult[7:0],
                 1'b0);
      push_write(operator_reg(ftrw_pkg::BASE_KSL, c.channel, 1'b1),
                 {car_scale_shadow[c.channel], ftrw_pkg::VOLUME_MAX - c.volume}, 1'b0);
      push_write(ftrw_pkg::BASE_FNUM_LO + {4'd0, c.channel}, fnum[7:0], 1'b0);
      push_write(ftrw_pkg::BASE_KEY_BLK + {4'd0, c.channel},
                 KEY_ON_BIT | {3'd0, blk, fnum[9:8]}, 1'b1);
   endfunction

   task automatic send_command(ftrw_pkg::req_type c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= c.mode;
      req_ch.channel     <= c.channel;
      req_ch.patch_index <= c.patch_index;
      req_ch.patch_byte  <= c.patch_byte;
      req_ch.frequency   <= c.frequency;
      req_ch.volume      <= c.volume;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_writes(c);
   endtask

   task automatic send_fields(logic mode, logic [3:0] ch, logic [3:0] idx, logic [7:0] pbyte,
                              logic [14:0] freq, logic [5:0] vol);
      ftrw_pkg::req_type c;
      c.mode        = mode;
      c.channel     = ch;
      c.patch_index = idx;
      c.patch_byte  = pbyte;
      c.frequency   = freq;
      c.volume      = vol;
      send_command(c);
   endtask

   task automatic wait_for_writes_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_writes.size() != 0) @(posedge clock);
   endtask

   function automatic ftrw_pkg::req_type random_command();
      ftrw_pkg::req_type c;
      int                r;
      c.mode        = ($urandom_range(0, 99) < 55) ? ftrw_pkg::MODE_TONE : ftrw_pkg::MODE_PATCH;
      c.channel     = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(0, 8));
      c.patch_index = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                   : 4'($urandom_range(0, 10));
      c.patch_byte  = 8'($urandom);
      // small multiplier nibbles keep most tones inside the scaling range
      if ((c.patch_index == ftrw_pkg::PIDX_MOD_CHARS ||
           c.patch_index == ftrw_pkg::PIDX_CAR_CHARS) && $urandom_range(0, 9) < 7)
         c.patch_byte[3:0] = 4'($urandom_range(0, 3));
      r = $urandom_range(0, 9);
      if (r < 4) c.frequency = 15'($urandom_range(0, 6249));
      else if (r < 7) c.frequency = 15'($urandom_range(6250, 12499));
      else c.frequency = 15'($urandom);
      c.volume = 6'($urandom);
      return c;
   endfunction

   task automatic test_patch_registers();
      logic [7:0] pbyte;
      for (int i = 0; i <= 10; i++) begin
         case (i % 3)
            0: pbyte = 8'hFF;
            1: pbyte = 8'h00;
            default: pbyte = 8'($urandom);
         endcase
         send_fields(ftrw_pkg::MODE_PATCH, 4'((i * 4) % ftrw_pkg::CHANNELS), 4'(i), pbyte,
                     15'($urandom), 6'($urandom));
      end
   endtask

   task automatic test_ignored_items();
      send_fields(ftrw_pkg::MODE_PATCH, 4'd2, 4'd15, 8'hFF, 15'h7FFF, 6'h3F);
      send_fields(ftrw_pkg::MODE_PATCH, 4'd15, ftrw_pkg::PIDX_FEEDBACK, 8'hA5, 15'd0, 6'd0);
      send_fields(ftrw_pkg::MODE_TONE, 4'd9, 4'd0, 8'h00, 15'd1000, 6'd20);
   endtask

   task automatic test_tone_extremes();
      send_fields(ftrw_pkg::MODE_PATCH, 4'd0, ftrw_pkg::PIDX_MOD_CHARS, 8'hF1, 15'd0, 6'd0);
      send_fields(ftrw_pkg::MODE_PATCH, 4'd0, ftrw_pkg::PIDX_CAR_CHARS, 8'h01, 15'd0, 6'd0);
      send_fields(ftrw_pkg::MODE_TONE, 4'd0, 4'd0, 8'h00, 15'd0, 6'd63);
      send_fields(ftrw_pkg::MODE_TONE, 4'd0, 4'd15, 8'hFF, 15'h7FFF, 6'd0);
      send_fields(ftrw_pkg::MODE_PATCH, 4'd8, ftrw_pkg::PIDX_MOD_CHARS, 8'h0F, 15'd0, 6'd0);
      // nibble of 15 fits only without scaling
      send_fields(ftrw_pkg::MODE_TONE, 4'd8, 4'd0, 8'h00, 15'd6249, 6'd31);
      send_fields(ftrw_pkg::MODE_TONE, 4'd8, 4'd0, 8'h00, 15'd6250, 6'd31);
      send_fields(ftrw_pkg::MODE_TONE, 4'd8, 4'd0, 8'h00, 15'd1, 6'($urandom));
      send_fields(ftrw_pkg::MODE_TONE, 4'd3, 4'd0, 8'h00, 15'd1000, 6'd10);
   endtask

   task automatic test_random_commands(int n_items);
      ftrw_pkg::req_type c;
      int                sent;
      sent = 0;
      while (sent < n_items) begin
         c = random_command();
         send_command(c);
         if (is_effective(c)) sent++;
      end
   endtask

   task automatic test_back_to_back(int n_items);
      no_gaps = 1'b1;
      test_random_commands(n_items);
      no_gaps = 1'b0;
   endtask

   initial begin
      rsp_ch.ready   <= 1'b0;
      rsp_stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 3) == 0) rsp_stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      reg_write_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected beat addr %h data %h last %b", $time,
                     rsp_ch.reg_addr, rsp_ch.reg_data, rsp_ch.last);
            err_count++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_ch.reg_addr !== want.addr) begin
               $display("%0t: reg_addr expected %h actual %h", $time, want.addr, rsp_ch.reg_addr);
               err_count++;
            end
            if (rsp_ch.reg_data !== want.data) begin
               $display("%0t: reg_data expected %h actual %h", $time, want.data, rsp_ch.reg_data);
               err_count++;
            end
            if (rsp_ch.last !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_ch.last);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
         $display("[fm_tone_register_writer] ERROR");
         $finish;
      end
   end

   initial begin
      bit missing;
      no_gaps = 1'b0;
      missing = 1'b0;
      for (int i = 0; i < ftrw_pkg::CHANNELS; i++) begin
         mod_chars_shadow[i] = 8'h00;
         car_chars_shadow[i] = 8'h00;
         car_scale_shadow[i] = 2'b00;
      end
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= ftrw_pkg::MODE_PATCH;
      req_ch.channel     <= 4'd0;
      req_ch.patch_index <= 4'd0;
      req_ch.patch_byte  <= 8'h00;
      req_ch.frequency   <= 15'd0;
      req_ch.volume      <= 6'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_patch_registers();
      test_ignored_items();
      test_tone_extremes();
      test_random_commands(220);
      wait_for_writes_drained();
      test_random_commands(200);
      test_back_to_back(60);

      wait_for_writes_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_writes.size() != 0) begin
         $display("%0t: %0d writes never arrived", $time, pending_writes.size());
         missing = 1'b1;
      end
      if (err_count == 0 && !missing)
         $display("[fm_tone_register_writer] OK");
      else
         $display("[fm_tone_register_writer] ERROR");
      $finish;
   end

endmodule
